// ===== rtl/lrmt_pkg.sv =====
// Shared types and constants for the LCD register file and mode timer.
`default_nettype none

package lrmt_pkg;

   localparam int TIMER_W = 18;

   localparam logic [TIMER_W-1:0] LINE_CYCLES  = TIMER_W'(456);
   localparam logic [TIMER_W-1:0] FRAME_CYCLES = TIMER_W'(70224);
   localparam logic [TIMER_W-1:0] OAM_START    = TIMER_W'(4);
   localparam logic [TIMER_W-1:0] VRAM_START   = TIMER_W'(84);
   localparam logic [TIMER_W-1:0] HBLANK_START = TIMER_W'(256);
   localparam logic [TIMER_W-1:0] VBLANK_START = TIMER_W'(65668);

   localparam logic [7:0] VISIBLE_LINES = 8'd144;
   localparam logic [7:0] LINE_RESET    = 8'd255;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_FRAME = 2'd3;

   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   localparam logic [7:0] ADDR_STAT = 8'h41;
   localparam logic [7:0] ADDR_SCY  = 8'h42;
   localparam logic [7:0] ADDR_SCX  = 8'h43;
   localparam logic [7:0] ADDR_LY   = 8'h44;
   localparam logic [7:0] ADDR_LYC  = 8'h45;
   localparam logic [7:0] ADDR_BGP  = 8'h47;
   localparam logic [7:0] ADDR_OBP0 = 8'h48;
   localparam logic [7:0] ADDR_OBP1 = 8'h49;
   localparam logic [7:0] ADDR_WY   = 8'h4A;
   localparam logic [7:0] ADDR_WX   = 8'h4B;

   // STAT bit positions
   localparam int STAT_COINC     = 2;
   localparam int STAT_HBLANK_IE = 3;
   localparam int STAT_VBLANK_IE = 4;
   localparam int STAT_OAM_IE    = 5;
   localparam int STAT_COINC_IE  = 6;

   typedef struct packed {
      logic       display_on;
      logic [7:0] tick_cycles;
      logic [7:0] write_data;
      logic [7:0] reg_addr;
      logic [1:0] func;
   } item_type;

   typedef struct packed {
      logic [7:0] draw_line;
      logic       draw_valid;
      logic       stat_irq;
      logic       vblank_irq;
      logic       restarted;
      logic [7:0] read_data;
   } result_type;

   typedef struct packed {
      logic step;
      logic load;
      logic run;
   } timer_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/lrmt_timer.sv =====
// One 18-bit phase timer: count down, expire at zero or below, reload.
`default_nettype none

module lrmt_timer
   import lrmt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire timer_ctl_type       ctl,
   input  wire logic [7:0]          cycles,
   input  wire logic [TIMER_W-1:0]  start_value,
   input  wire logic [TIMER_W-1:0]  reload,
   output logic                     expired
);

   logic [TIMER_W-1:0] timer_ff;
   logic [TIMER_W-1:0] timer_in;
   logic [TIMER_W-1:0] base;
   logic [TIMER_W-1:0] diff;

   assign base    = ctl.load ? start_value : timer_ff;
   assign diff    = base - {{(TIMER_W-8){1'b0}}, cycles};
   assign expired = (diff == '0) || diff[TIMER_W-1];

   always_comb begin
      timer_in = timer_ff;
      if (ctl.step) begin
         if (ctl.run) begin
            timer_in = expired ? (diff + reload) : diff;
         end else begin
            timer_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= start_value;
      end else begin
         timer_ff <= timer_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lrmt_core.sv =====
// Register file, line counter and STAT logic driven by the four phase timers.
`default_nettype none

module lrmt_core
   import lrmt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  wire item_type  item,
   output result_type     result
);

   logic [7:0] line_ff, line_in;
   logic [7:0] lyc_ff, lyc_in;
   logic [7:0] stat_ff, stat_in;
   logic       restart_ff, restart_in;
   logic [7:0] pal_ff [3];
   logic [7:0] pal_in [3];
   logic [7:0] scroll_ff [4];
   logic [7:0] scroll_in [4];

   logic          is_timed;
   logic          is_frame;
   timer_ctl_type tctl;
   logic          oam_exp, xfer_exp, hb_exp, vb_exp;

   assign is_frame = (item.func == FUNC_FRAME);
   assign is_timed = (item.func == FUNC_TICK) || is_frame;

   assign tctl.step = step;
   assign tctl.load = is_frame;
   assign tctl.run  = is_timed && item.display_on && !restart_ff;

   lrmt_timer u_oam (
      .clock, .reset, .ctl(tctl), .cycles(is_frame ? 8'd0 : item.tick_cycles),
      .start_value(OAM_START), .reload(LINE_CYCLES), .expired(oam_exp)
   );
   lrmt_timer u_xfer (
      .clock, .reset, .ctl(tctl), .cycles(is_frame ? 8'd0 : item.tick_cycles),
      .start_value(VRAM_START), .reload(LINE_CYCLES), .expired(xfer_exp)
   );
   lrmt_timer u_hblank (
      .clock, .reset, .ctl(tctl), .cycles(is_frame ? 8'd0 : item.tick_cycles),
      .start_value(HBLANK_START), .reload(LINE_CYCLES), .expired(hb_exp)
   );
   lrmt_timer u_vblank (
      .clock, .reset, .ctl(tctl), .cycles(is_frame ? 8'd0 : item.tick_cycles),
      .start_value(VBLANK_START), .reload(FRAME_CYCLES), .expired(vb_exp)
   );

   always_comb begin
      result     = '0;
      line_in    = line_ff;
      lyc_in     = lyc_ff;
      stat_in    = stat_ff;
      restart_in = restart_ff;
      pal_in     = pal_ff;
      scroll_in  = scroll_ff;
      if (item.func == FUNC_WRITE) begin
         unique case (item.reg_addr)
            ADDR_STAT: stat_in      = {item.write_data[7:3], stat_ff[2:0]};
            ADDR_SCY:  scroll_in[0] = item.write_data;
            ADDR_SCX:  scroll_in[1] = item.write_data;
            ADDR_LY:   restart_in   = 1'b1;
            ADDR_LYC:  lyc_in       = item.write_data;
            ADDR_BGP:  pal_in[0]    = item.write_data;
            ADDR_OBP0: pal_in[1]    = item.write_data;
            ADDR_OBP1: pal_in[2]    = item.write_data;
            ADDR_WY:   scroll_in[2] = item.write_data;
            ADDR_WX:   scroll_in[3] = item.write_data;
            default: ;
         endcase
      end else if (item.func == FUNC_READ) begin
         unique case (item.reg_addr)
            ADDR_STAT: result.read_data = stat_ff;
            ADDR_SCY:  result.read_data = scroll_ff[0];
            ADDR_SCX:  result.read_data = scroll_ff[1];
            ADDR_LY:   result.read_data = line_ff;
            ADDR_LYC:  result.read_data = lyc_ff;
            ADDR_BGP:  result.read_data = pal_ff[0];
            ADDR_OBP0: result.read_data = pal_ff[1];
            ADDR_OBP1: result.read_data = pal_ff[2];
            ADDR_WY:   result.read_data = scroll_ff[2];
            ADDR_WX:   result.read_data = scroll_ff[3];
            default:   result.read_data = 8'd0;
         endcase
      end else begin
         if (is_frame) begin
            line_in = LINE_RESET;
         end
         if (!item.display_on) begin
            restart_in = 1'b1;
         end else if (restart_ff) begin
            restart_in       = 1'b0;
            result.restarted = 1'b1;
         end else begin
            if (oam_exp) begin
               line_in = line_in + 8'd1;
               if (line_in == lyc_ff) begin
                  stat_in[STAT_COINC] = 1'b1;
                  if (stat_ff[STAT_COINC_IE]) result.stat_irq = 1'b1;
               end else begin
                  stat_in[STAT_COINC] = 1'b0;
               end
               if (line_in < VISIBLE_LINES) begin
                  stat_in[1:0] = MODE_OAM;
                  if (stat_ff[STAT_OAM_IE]) result.stat_irq = 1'b1;
               end
            end
            if (xfer_exp && (line_in < VISIBLE_LINES)) begin
               stat_in[1:0] = MODE_TRANSFER;
            end
            if (hb_exp && (line_in < VISIBLE_LINES)) begin
               stat_in[1:0]      = MODE_HBLANK;
               if (stat_ff[STAT_HBLANK_IE]) result.stat_irq = 1'b1;
               result.draw_valid = 1'b1;
               result.draw_line  = line_in;
            end
            if (vb_exp) begin
               stat_in[1:0]      = MODE_VBLANK;
               result.vblank_irq = 1'b1;
               if (stat_ff[STAT_VBLANK_IE]) result.stat_irq = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= LINE_RESET;
         lyc_ff     <= 8'd0;
         stat_ff    <= 8'd0;
         restart_ff <= 1'b0;
         pal_ff     <= '{default: 8'd0};
         scroll_ff  <= '{default: 8'd0};
      end else if (step) begin
         line_ff    <= line_in;
         lyc_ff     <= lyc_in;
         stat_ff    <= stat_in;
         restart_ff <= restart_in;
         pal_ff     <= pal_in;
         scroll_ff  <= scroll_in;
      end
   end

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      step && result.vblank_irq |=> stat_ff[1:0] == MODE_VBLANK)
      else $error("vblank pulse without vblank mode");

   a_restart_quiet: assert property (@(posedge clock) disable iff (reset)
      step && result.restarted |-> !result.vblank_irq && !result.stat_irq
                                   && !result.draw_valid)
      else $error("restart transaction produced events");

   a_draw_visible: assert property (@(posedge clock) disable iff (reset)
      step && result.draw_valid |-> result.draw_line < VISIBLE_LINES)
      else $error("draw request outside visible lines");

   a_ly_write: assert property (@(posedge clock) disable iff (reset)
      step && item.func == FUNC_WRITE && item.reg_addr == ADDR_LY |=> restart_ff)
      else $error("LY write did not arm restart");

endmodule

`default_nettype wire

// ===== rtl/lcd_register_and_mode_timer.sv =====
// Top level: input register, register file and timers, result register.
`default_nettype none

// LCD register file and mode timer. Each request transaction (tick, register
// write, register read or frame start) yields exactly one response
// transaction. One request is taken every clock cycle unless the response
// stalls. Requests pass the request register, a single-pass state update
// and the response register. A stalled response holds both stages, and
// req_tready follows rsp_tready while both stages are full.
module lcd_register_and_mode_timer
   import lrmt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] reg_addr, [15:8] write_data, [23:16] tick_cycles, [24] display_on
   input  wire logic [31:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data, [8] restarted, [9] vblank_irq, [10] stat_irq,
   // [11] draw_valid, [19:12] draw_line
   output logic [23:0]      rsp_tdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff;
   result_type res_comb;
   logic       advance;
   logic       step;
   logic       req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   lrmt_core u_core (
      .clock, .reset, .step, .item(item_ff), .result(res_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func        <= req_tuser;
         item_ff.reg_addr    <= req_tdata[7:0];
         item_ff.write_data  <= req_tdata[15:8];
         item_ff.tick_cycles <= req_tdata[23:16];
         item_ff.display_on  <= req_tdata[24];
      end
      if (step) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, res_ff.draw_line, res_ff.draw_valid, res_ff.stat_irq,
                        res_ff.vblank_irq, res_ff.restarted, res_ff.read_data};

endmodule

`default_nettype wire

// ===== bench/lcd_register_and_mode_timer_tb.sv =====
// Testbench for the LCD register file and mode timer: directed table, random traffic.
`timescale 1ns / 100ps

module lcd_register_and_mode_timer_tb
   import lrmt_pkg::*;
();

   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] tick_cycles;
      logic       display_on;
      logic       typed;
      logic [7:0] typed_read;
      logic       typed_restart;
   } dir_row_type;

   localparam int DIR_ROWS = 26;
   // rows marked typed carry their expected read_data / restarted
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      {FUNC_READ,  ADDR_STAT, 8'h00, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  ADDR_LY,   8'h00, 8'd0,   1'b1, 1'b1, 8'hFF, 1'b0},
      {FUNC_READ,  ADDR_LYC,  8'h00, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  8'h00,     8'h00, 8'd0,   1'b0, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  8'hFF,     8'hFF, 8'hFF,  1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_WRITE, ADDR_BGP,  8'hFF, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  ADDR_BGP,  8'h00, 8'd0,   1'b1, 1'b1, 8'hFF, 1'b0},
      {FUNC_WRITE, 8'hFF,     8'hFF, 8'hFF,  1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_WRITE, 8'h46,     8'hA5, 8'd0,   1'b0, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  8'h46,     8'h00, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_WRITE, ADDR_STAT, 8'hFF, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  ADDR_STAT, 8'h00, 8'd0,   1'b1, 1'b1, 8'hF8, 1'b0},
      {FUNC_WRITE, ADDR_LYC,  8'h00, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd4,   1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_READ,  ADDR_STAT, 8'h00, 8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd255, 1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd255, 1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_WRITE, ADDR_LY,   8'h5A, 8'd0,   1'b1, 1'b1, 8'h00, 1'b0},
      {FUNC_READ,  ADDR_LY,   8'h00, 8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd255, 1'b1, 1'b1, 8'h00, 1'b1},
      {FUNC_TICK,  8'h00,     8'h00, 8'd200, 1'b0, 1'b1, 8'h00, 1'b0},
      {FUNC_FRAME, 8'h00,     8'h00, 8'd77,  1'b1, 1'b1, 8'h00, 1'b1},
      {FUNC_FRAME, 8'h00,     8'h00, 8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
      {FUNC_FRAME, 8'h00,     8'h00, 8'd0,   1'b0, 1'b1, 8'h00, 1'b0},
      {FUNC_TICK,  8'h00,     8'h00, 8'd0,   1'b1, 1'b1, 8'h00, 1'b1}
   };

   localparam logic [7:0] REG_ADDRS [10] = '{
      ADDR_STAT, ADDR_SCY, ADDR_SCX, ADDR_LY, ADDR_LYC,
      ADDR_BGP, ADDR_OBP0, ADDR_OBP1, ADDR_WY, ADDR_WX
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [7:0] reg_addr, [15:8] write_data, [23:16] tick_cycles, [24] display_on
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] read_data, [8] restarted, [9] vblank_irq, [10] stat_irq,
   // [11] draw_valid, [19:12] draw_line
   logic [23:0] rsp_tdata;

   // predicted block state
   logic [TIMER_W-1:0] oam_left, xfer_left, hblank_left, vblank_left;
   logic [7:0]         ly, lyc, stat;
   logic               restart_due;
   logic [7:0]         bgp, obp0, obp1, scy, scx, wy, wx;

   result_type due_results [$];
   int         mismatches   = 0;
   int         idle_cycles  = 0;
   logic       quiet_period = 1'b0;

   lcd_register_and_mode_timer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic timer_done(input logic [TIMER_W-1:0] t);
      return t == '0 || t[TIMER_W-1];
   endfunction

   // advance the predicted state by one transaction and return its response
   function automatic result_type lcd_apply(input item_type it);
      result_type         r;
      logic [TIMER_W-1:0] cyc;
      r = '0;
      case (it.func)
         FUNC_WRITE: begin
            case (it.reg_addr)
               ADDR_STAT: stat = (stat & 8'h07) | (it.write_data & 8'hF8);
               ADDR_SCY:  scy = it.write_data;
               ADDR_SCX:  scx = it.write_data;
               ADDR_LY:   restart_due = 1'b1;
               ADDR_LYC:  lyc = it.write_data;
               ADDR_BGP:  bgp = it.write_data;
               ADDR_OBP0: obp0 = it.write_data;
               ADDR_OBP1: obp1 = it.write_data;
               ADDR_WY:   wy = it.write_data;
               ADDR_WX:   wx = it.write_data;
               default: ;
            endcase
         end
         FUNC_READ: begin
            case (it.reg_addr)
               ADDR_STAT: r.read_data = stat;
               ADDR_SCY:  r.read_data = scy;
               ADDR_SCX:  r.read_data = scx;
               ADDR_LY:   r.read_data = ly;
               ADDR_LYC:  r.read_data = lyc;
               ADDR_BGP:  r.read_data = bgp;
               ADDR_OBP0: r.read_data = obp0;
               ADDR_OBP1: r.read_data = obp1;
               ADDR_WY:   r.read_data = wy;
               ADDR_WX:   r.read_data = wx;
               default:   r.read_data = 8'h00;
            endcase
         end
         default: begin
            cyc = TIMER_W'(it.tick_cycles);
            if (it.func == FUNC_FRAME) begin
               oam_left    = OAM_START;
               xfer_left   = VRAM_START;
               hblank_left = HBLANK_START;
               vblank_left = VBLANK_START;
               ly          = LINE_RESET;
               cyc         = '0;
            end
            if (!it.display_on) begin
               restart_due = 1'b1;
            end else if (restart_due) begin
               restart_due = 1'b0;
               r.restarted = 1'b1;
            end else begin
               oam_left    = oam_left - cyc;
               xfer_left   = xfer_left - cyc;
               hblank_left = hblank_left - cyc;
               vblank_left = vblank_left - cyc;
               if (timer_done(oam_left)) begin
                  ly = ly + 8'd1;
                  if (ly == lyc) begin
                     stat[STAT_COINC] = 1'b1;
                     if (stat[STAT_COINC_IE]) r.stat_irq = 1'b1;
                  end else begin
                     stat[STAT_COINC] = 1'b0;
                  end
                  if (ly < VISIBLE_LINES) begin
                     stat[1:0] = MODE_OAM;
                     if (stat[STAT_OAM_IE]) r.stat_irq = 1'b1;
                  end
                  oam_left = oam_left + LINE_CYCLES;
               end
               if (timer_done(xfer_left)) begin
                  if (ly < VISIBLE_LINES) stat[1:0] = MODE_TRANSFER;
                  xfer_left = xfer_left + LINE_CYCLES;
               end
               if (timer_done(hblank_left)) begin
                  if (ly < VISIBLE_LINES) begin
                     stat[1:0] = MODE_HBLANK;
                     if (stat[STAT_HBLANK_IE]) r.stat_irq = 1'b1;
                     r.draw_valid = 1'b1;
                     r.draw_line  = ly;
                  end
                  hblank_left = hblank_left + LINE_CYCLES;
               end
               if (timer_done(vblank_left)) begin
                  stat[1:0] = MODE_VBLANK;
                  r.vblank_irq = 1'b1;
                  if (stat[STAT_VBLANK_IE]) r.stat_irq = 1'b1;
                  vblank_left = vblank_left + FRAME_CYCLES;
               end
            end
         end
      endcase
      return r;
   endfunction

   // present one request; valid stays high on return for back-to-back transactions
   task automatic issue(input item_type it, input logic typed, input result_type typed_rsp);
      result_type predicted;
      req_tdata  <= {7'd0, it.display_on, it.tick_cycles, it.write_data, it.reg_addr};
      req_tuser  <= it.func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = lcd_apply(it);
      due_results.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic idle_gap();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      len  = 0;
      if (!quiet_period) begin
         if (pick >= 92)      len = $urandom_range(8, 40);
         else if (pick >= 60) len = $urandom_range(1, 3);
      end
      if (len > 0) begin
         req_tvalid <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   initial begin
      item_type   it;
      result_type typed_rsp;
      int         sel;
      oam_left    = OAM_START;
      xfer_left   = VRAM_START;
      hblank_left = HBLANK_START;
      vblank_left = VBLANK_START;
      ly          = LINE_RESET;
      lyc         = '0;
      stat        = '0;
      restart_due = 1'b0;
      {bgp, obp0, obp1, scy, scx, wy, wx} = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         it.func        = DIRECTED[i].func;
         it.reg_addr    = DIRECTED[i].reg_addr;
         it.write_data  = DIRECTED[i].write_data;
         it.tick_cycles = DIRECTED[i].tick_cycles;
         it.display_on  = DIRECTED[i].display_on;
         typed_rsp           = '0;
         typed_rsp.read_data = DIRECTED[i].typed_read;
         typed_rsp.restarted = DIRECTED[i].typed_restart;
         issue(it, DIRECTED[i].typed, typed_rsp);
         idle_gap();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) quiet_period = ($urandom_range(0, 3) == 0);
         it.reg_addr    = 8'($urandom_range(0, 255));
         it.write_data  = 8'($urandom_range(0, 255));
         it.tick_cycles = 8'($urandom_range(0, 255));
         it.display_on  = 1'b1;
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            // mostly long ticks so the run crosses several frames
            it.func = FUNC_TICK;
            if ($urandom_range(0, 9) != 0) it.tick_cycles = 8'($urandom_range(180, 255));
            if ($urandom_range(0, 99) < 3) it.display_on = 1'b0;
         end else if (sel < 82) begin
            it.func = FUNC_WRITE;
            if ($urandom_range(0, 7) != 0) it.reg_addr = REG_ADDRS[$urandom_range(0, 9)];
            if (it.reg_addr == ADDR_LYC && $urandom_range(0, 3) != 0)
               it.write_data = 8'($urandom_range(0, 153));
         end else if (sel < 99) begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 7) != 0) it.reg_addr = REG_ADDRS[$urandom_range(0, 9)];
         end else begin
            it.func = FUNC_FRAME;
            it.display_on = ($urandom_range(0, 3) != 0);
         end
         issue(it, 1'b0, '0);
         idle_gap();
      end

      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // response backpressure: short and long stalls, occasional long ready stretches
   initial begin
      int run_len;
      int stall_len;
      wait (!reset);
      forever begin
         run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
         stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         rsp_tready <= 1'b0;
         repeat (stall_len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      got = rsp_tdata[$bits(result_type)-1:0];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response transaction: %h", rsp_tdata);
         end else begin
            want = due_results.pop_front();
            if (got.read_data !== want.read_data || got.restarted !== want.restarted ||
                got.vblank_irq !== want.vblank_irq || got.stat_irq !== want.stat_irq ||
                got.draw_valid !== want.draw_valid || got.draw_line !== want.draw_line) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response mismatch: exp rd=%h rst=%b vb=%b st=%b dv=%b dl=%0d",
                            " / got rd=%h rst=%b vb=%b st=%b dv=%b dl=%0d"},
                           want.read_data, want.restarted, want.vblank_irq, want.stat_irq,
                           want.draw_valid, want.draw_line,
                           got.read_data, got.restarted, got.vblank_irq, got.stat_irq,
                           got.draw_valid, got.draw_line);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
